### design/psm_pkg.sv
// Shared types and constants for the polar bin scatter-mean block.
// Depends on nothing; psm_div and polar_bin_scatter_mean import it.
`default_nettype none
package psm_pkg;

   localparam int VAL_W = 24;
   localparam int SUM_W = 40;
   localparam int HIT_W = 16;

   localparam logic [1:0] ACT_BIN  = 2'd0;
   localparam logic [1:0] ACT_FILL = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] STAT_EMPTY  = 2'd0;
   localparam logic [1:0] STAT_MEAN   = 2'd1;
   localparam logic [1:0] STAT_FILLED = 2'd2;

   localparam logic [1:0] REG_COLS   = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;

   localparam logic [HIT_W-1:0] HIT_FULL = '1;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [HIT_W-1:0] hits;
      logic             saturated;
      logic [VAL_W-1:0] fill_value;
      logic             filled;
   } cell_entry_type;

   typedef struct packed {
      logic             usable;
      logic [VAL_W-1:0] value;
   } bin_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

### design/psm_ram.sv
// Single-port-write, single-read synchronous memory with registered read data.
// Depends on nothing; used for the cell table and the bin table.
`default_nettype none
module psm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### design/psm_div.sv
// Bit-serial restoring divider: signed sum over unsigned hit count, truncated.
// Depends on psm_pkg for the operand widths.
`default_nettype none
module psm_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [psm_pkg::SUM_W-1:0] dividend,
   input  wire logic [psm_pkg::HIT_W-1:0] divisor,
   output logic                           done,
   output logic      [psm_pkg::VAL_W-1:0] quotient
);
   import psm_pkg::*;

   localparam int CW = $clog2(SUM_W);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [HIT_W-1:0] rem_ff, rem_in;
   logic [HIT_W-1:0] dsr_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [HIT_W:0]   trial;
   logic [SUM_W-1:0] signed_q;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      quo_in  = {quo_ff[SUM_W-2:0], 1'b0};
      rem_in  = trial[HIT_W-1:0];
      if (trial >= {1'b0, dsr_ff}) begin
         rem_in    = HIT_W'(trial - {1'b0, dsr_ff});
         quo_in[0] = 1'b1;
      end
      cnt_in  = cnt_ff + CW'(1);
      busy_in = busy_ff && (cnt_ff != CW'(SUM_W - 1));
      done_in = busy_ff && (cnt_ff == CW'(SUM_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start ? 1'b1 : busy_in;
         done_ff <= start ? 1'b0 : done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         cnt_ff <= '0;
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   assign signed_q = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
   assign quotient = signed_q[VAL_W-1:0];
   assign done     = done_ff;

endmodule
`default_nettype wire

### design/polar_bin_scatter_mean.sv
// Polar bin scatter-mean: accumulates radar bins into a cell table held in memory.
// Top level; depends on psm_pkg, psm_ram and psm_div.
//
// Usage. Request words arrive on the req_ channel (valid/ready). A bin word stores the
// bin value and its usable mark in the bin table and, when usable and in bounds, adds
// the value and one hit to the addressed cell. A fill word copies a usable stored bin
// value into a cell's fill slot. A read word returns one response word on the rsp_
// channel (mean, fill value or empty) and clears the cell. Other words give nothing.
// Registers are written through the csr_ channel, which is always ready; write them only
// while the block is idle.
// Timing. The block works on one word at a time: the cell and bin memories are read in
// one cycle, and the read data is modified and written back in the next. A bin or fill
// word passes through the idle, look and exec states. A read word of an empty or filled
// cell then loads its response in the out state; a read of a cell with hits first runs
// the 40-step serial divider.
// Reset. After reset the block sweeps all GRID_ROWS*GRID_COLS entries (65536 by default)
// of the cell memory clear, one entry a cycle; req_ready stays low meanwhile.
// Stalls. The response sits in an output register. A new request is accepted while it
// waits; a further read response waits in the block until the register frees.
`default_nettype none
module polar_bin_scatter_mean #(
   parameter int GRID_ROWS = 256,
   parameter int GRID_COLS = 256,
   parameter int BIN_SLOTS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic signed [23:0] req_sample_value,
   input  wire logic        req_value_finite,
   input  wire logic [15:0] req_beam_height,
   input  wire logic        req_in_bounds,
   input  wire logic [7:0]  req_grid_row,
   input  wire logic [7:0]  req_grid_col,
   input  wire logic [15:0] req_bin_number,
   input  wire logic [15:0] req_cell_number,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [23:0] rsp_cell_value,
   output logic [1:0]       rsp_cell_status,
   output logic [15:0]      rsp_hit_total,
   output logic             rsp_hits_saturated,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import psm_pkg::*;

   localparam int CELL_SLOTS = GRID_ROWS * GRID_COLS;
   localparam int CELL_AW    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
   localparam int BIN_AW     = (BIN_SLOTS > 1) ? $clog2(BIN_SLOTS) : 1;
   localparam int CELL_W     = $bits(cell_entry_type);
   localparam int BIN_W      = $bits(bin_entry_type);

   // Configuration registers.
   logic [8:0]  cols_ff;
   logic [15:0] max_height_ff;

   // Control state.
   state_type     state_ff, state_in;
   logic [CELL_AW-1:0] clr_cnt_ff;
   logic          rsp_valid_ff;

   // Request word held while it is worked on.
   logic [1:0]       act_ff;
   logic [VAL_W-1:0] val_ff;
   logic             fin_ff;
   logic [15:0]      hgt_ff;
   logic             inb_ff;
   logic [7:0]       row_ff;
   logic [7:0]       col_ff;
   logic [15:0]      bin_ff;
   logic [15:0]      celln_ff;

   // Pending and delivered response.
   logic [VAL_W-1:0] pend_value_ff;
   logic [1:0]       pend_status_ff;
   logic [HIT_W-1:0] pend_hits_ff;
   logic             pend_sat_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [1:0]       rsp_status_ff;
   logic [HIT_W-1:0] rsp_hits_ff;
   logic             rsp_sat_ff;

   // Control strobes from the state machine.
   logic req_take, clr_we, exec_en, div_start, rsp_load, clr_last;

   // Datapath.
   logic [17:0]         grid_addr;
   logic [17:0]         cell_sel;
   logic                grid_ok, celln_ok, bin_ok, usable, need_div;
   logic [CELL_AW-1:0]  cell_idx;
   logic [BIN_AW-1:0]   bin_idx;
   cell_entry_type      cell_rd, cell_upd;
   bin_entry_type       bin_rd, bin_wr;
   logic [CELL_W-1:0]   cell_rd_raw, cell_wr_raw;
   logic [BIN_W-1:0]    bin_rd_raw;
   logic                cell_we, bin_we;
   logic [CELL_AW-1:0]  cell_wr_addr;
   logic                div_done;
   logic [VAL_W-1:0]    div_q;

   // The row stride comes from a register, so the cell address is a small multiply-add.
   assign grid_addr = 18'(row_ff) * 18'(cols_ff) + 18'(col_ff);
   assign grid_ok   = 32'(grid_addr) < 32'(CELL_SLOTS);
   assign celln_ok  = 32'(celln_ff) < 32'(CELL_SLOTS);
   assign bin_ok    = 32'(bin_ff) < 32'(BIN_SLOTS);
   assign usable    = fin_ff && (hgt_ff <= max_height_ff);
   assign cell_sel  = (act_ff == ACT_BIN) ? grid_addr : 18'(celln_ff);
   assign cell_idx  = CELL_AW'(32'(cell_sel));
   assign bin_idx   = BIN_AW'(32'(bin_ff));

   assign cell_rd   = cell_entry_type'(cell_rd_raw);
   assign bin_rd    = bin_entry_type'(bin_rd_raw);
   assign need_div  = celln_ok && (cell_rd.hits != '0);

   // Read-modify-write of the addressed cell. Only one word is in flight, so a write
   // always lands before the next read of the same entry.
   always_comb begin
      cell_upd = cell_rd;
      cell_we  = 1'b0;
      unique case (act_ff)
         ACT_BIN: begin
            if (usable && inb_ff && grid_ok) begin
               cell_we = 1'b1;
               if (cell_rd.hits == HIT_FULL) begin
                  cell_upd.saturated = 1'b1;
               end else begin
                  cell_upd.sum  = cell_rd.sum + {{(SUM_W-VAL_W){val_ff[VAL_W-1]}}, val_ff};
                  cell_upd.hits = cell_rd.hits + HIT_W'(1);
               end
            end
         end
         ACT_FILL: begin
            if (celln_ok && bin_ok && bin_rd.usable) begin
               cell_we             = 1'b1;
               cell_upd.fill_value = bin_rd.value;
               cell_upd.filled     = 1'b1;
            end
         end
         ACT_READ: begin
            cell_we  = celln_ok;
            cell_upd = '0;
         end
         default: begin
            cell_we = 1'b0;
         end
      endcase
   end

   assign bin_wr       = '{usable: usable, value: val_ff};
   assign bin_we       = exec_en && (act_ff == ACT_BIN) && bin_ok;
   assign cell_wr_addr = clr_we ? clr_cnt_ff : cell_idx;
   assign cell_wr_raw  = clr_we ? '0 : CELL_W'(cell_upd);
   assign clr_last     = (clr_cnt_ff == CELL_AW'(CELL_SLOTS - 1));

   psm_ram #(.WIDTH(CELL_W), .DEPTH(CELL_SLOTS), .AW(CELL_AW)) u_cell_ram (
      .clock   (clock),
      .wr_en   (clr_we || (exec_en && cell_we)),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_raw),
      .rd_addr (cell_idx),
      .rd_data (cell_rd_raw)
   );

   psm_ram #(.WIDTH(BIN_W), .DEPTH(BIN_SLOTS), .AW(BIN_AW)) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_idx),
      .wr_data (BIN_W'(bin_wr)),
      .rd_addr (bin_idx),
      .rd_data (bin_rd_raw)
   );

   psm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cell_rd.sum),
      .divisor  (cell_rd.hits),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_LOOK;
         ST_LOOK:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (act_ff == ACT_READ) begin
               state_in = need_div ? ST_DIV : ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:   if (div_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_take  = 1'b0;
      clr_we    = 1'b0;
      exec_en   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clr_we   = 1'b1;
         ST_IDLE:  req_take = 1'b1;
         ST_LOOK:  ;
         ST_EXEC: begin
            exec_en   = 1'b1;
            div_start = (act_ff == ACT_READ) && need_div;
         end
         ST_DIV:   ;
         ST_OUT:   rsp_load = !rsp_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   assign req_ready = req_take;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         cols_ff       <= 9'd256;
         max_height_ff <= 16'hFFFF;
      end else begin
         state_ff <= state_in;
         if (clr_we) begin
            clr_cnt_ff <= clr_cnt_ff + CELL_AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == REG_COLS) begin
               cols_ff <= csr_data[8:0];
            end else if (csr_index == REG_HEIGHT) begin
               max_height_ff <= csr_data;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take && req_valid) begin
         act_ff   <= req_action;
         val_ff   <= req_sample_value;
         fin_ff   <= req_value_finite;
         hgt_ff   <= req_beam_height;
         inb_ff   <= req_in_bounds;
         row_ff   <= req_grid_row;
         col_ff   <= req_grid_col;
         bin_ff   <= req_bin_number;
         celln_ff <= req_cell_number;
      end
      if (exec_en && (act_ff == ACT_READ)) begin
         pend_sat_ff <= celln_ok && cell_rd.saturated;
         if (need_div) begin
            pend_status_ff <= STAT_MEAN;
            pend_hits_ff   <= cell_rd.hits;
            pend_value_ff  <= '0;
         end else begin
            pend_hits_ff <= '0;
            if (celln_ok && cell_rd.filled) begin
               pend_status_ff <= STAT_FILLED;
               pend_value_ff  <= cell_rd.fill_value;
            end else begin
               pend_status_ff <= STAT_EMPTY;
               pend_value_ff  <= '0;
            end
         end
      end else if (div_done) begin
         pend_value_ff <= div_q;
      end
      if (rsp_load) begin
         rsp_value_ff  <= pend_value_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_hits_ff   <= pend_hits_ff;
         rsp_sat_ff    <= pend_sat_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_value     = rsp_value_ff;
   assign rsp_cell_status    = rsp_status_ff;
   assign rsp_hit_total      = rsp_hits_ff;
   assign rsp_hits_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

### tb/tb_polar_bin_scatter_mean.sv
// Self-checking testbench for polar_bin_scatter_mean: random and directed request words,
// a built-in scatter-mean predictor and a response checker. Depends on psm_pkg and the RTL.
`timescale 1ns / 100ps
module tb_polar_bin_scatter_mean;
   import psm_pkg::*;

   localparam int CELLS = 65536;
   localparam int BINS = 65536;

   // The one action code that does nothing.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // One request word as the driver presents it.
   typedef struct packed {
      logic [1:0]  action;
      logic [23:0] value;
      logic        finite;
      logic [15:0] height;
      logic        inb;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [15:0] bin;
      logic [15:0] cell_no;
   } req_word_type;

   localparam int REQ_W = $bits(req_word_type);

   // One expected response word.
   typedef struct packed {
      logic [23:0] value;
      logic [1:0]  status;
      logic [15:0] hits;
      logic        sat;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic signed [23:0] req_sample_value = '0;
   logic        req_value_finite = 1'b0;
   logic [15:0] req_beam_height = '0;
   logic        req_in_bounds = 1'b0;
   logic [7:0]  req_grid_row = '0;
   logic [7:0]  req_grid_col = '0;
   logic [15:0] req_bin_number = '0;
   logic [15:0] req_cell_number = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [23:0] rsp_cell_value;
   logic [1:0]  rsp_cell_status;
   logic [15:0] rsp_hit_total;
   logic        rsp_hits_saturated;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   polar_bin_scatter_mean uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_sample_value(req_sample_value), .req_value_finite(req_value_finite),
      .req_beam_height(req_beam_height), .req_in_bounds(req_in_bounds),
      .req_grid_row(req_grid_row), .req_grid_col(req_grid_col),
      .req_bin_number(req_bin_number), .req_cell_number(req_cell_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cell_value(rsp_cell_value),
      .rsp_cell_status(rsp_cell_status), .rsp_hit_total(rsp_hit_total),
      .rsp_hits_saturated(rsp_hits_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // The predictor's own copy of the cell table, bin table and registers. Cell
   // sums are kept at 40 bits, the width the block accumulates in.
   logic signed [39:0] cell_sum[CELLS];
   logic [15:0]        cell_hits[CELLS];
   logic               cell_sat[CELLS];
   logic [23:0]        cell_fill[CELLS];
   logic               cell_filled[CELLS];
   logic [23:0]        bin_value[BINS];
   logic               bin_usable[BINS];
   bit                 bin_written[BINS];
   logic [8:0]         cols_in_use;
   logic [15:0]        max_height;

   req_word_type pending_words[$];
   rsp_word_type expected_cells[$];

   int  error_count = 0;
   int  words_checked = 0;
   int  send_idle_pct = 9;
   int  recv_idle_pct = 58;
   bit  recv_hold = 1'b0;
   int  hold_cycles = 0;
   bit  req_taken = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000_000;
      $display("polar_bin_scatter_mean: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      error_count++;
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Applies one accepted request word to the predictor and queues any response.
   task automatic predict_cell_table(input req_word_type w);
      logic               usable;
      logic [17:0]        addr;
      logic signed [39:0] mean;
      rsp_word_type       r;
      case (w.action)
         ACT_BIN: begin
            usable = w.finite && (w.height <= max_height);
            bin_value[w.bin] = w.value;
            bin_usable[w.bin] = usable;
            bin_written[w.bin] = 1'b1;
            addr = w.row * cols_in_use + w.col;
            if (usable && w.inb && addr < CELLS) begin
               if (cell_hits[addr] == HIT_FULL) begin
                  cell_sat[addr] = 1'b1;
               end else begin
                  cell_sum[addr] += {{16{w.value[23]}}, w.value};
                  cell_hits[addr]++;
               end
            end
         end
         ACT_FILL: begin
            if (bin_usable[w.bin]) begin
               cell_fill[w.cell_no] = bin_value[w.bin];
               cell_filled[w.cell_no] = 1'b1;
            end
         end
         ACT_READ: begin
            r = '0;
            r.hits = cell_hits[w.cell_no];
            r.sat = cell_sat[w.cell_no];
            if (cell_hits[w.cell_no] != 0) begin
               // SystemVerilog signed division truncates toward zero.
               mean = cell_sum[w.cell_no] / $signed({24'd0, cell_hits[w.cell_no]});
               r.value = mean[23:0];
               r.status = STAT_MEAN;
            end else if (cell_filled[w.cell_no]) begin
               r.value = cell_fill[w.cell_no];
               r.status = STAT_FILLED;
            end else begin
               r.status = STAT_EMPTY;
            end
            cell_sum[w.cell_no] = '0;
            cell_hits[w.cell_no] = '0;
            cell_sat[w.cell_no] = 1'b0;
            cell_fill[w.cell_no] = '0;
            cell_filled[w.cell_no] = 1'b0;
            expected_cells.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Driver: presents the oldest pending word at the falling edge. Valid stays
   // high until the word is taken, and a new word can follow without a gap when the sender does not idle.
   always @(negedge clock) begin
      if (!reset) begin
         if ((!req_valid || req_taken) && pending_words.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_action <= pending_words[0].action;
            req_sample_value <= pending_words[0].value;
            req_value_finite <= pending_words[0].finite;
            req_beam_height <= pending_words[0].height;
            req_in_bounds <= pending_words[0].inb;
            req_grid_row <= pending_words[0].row;
            req_grid_col <= pending_words[0].col;
            req_bin_number <= pending_words[0].bin;
            req_cell_number <= pending_words[0].cell_no;
         end else if (req_taken) begin
            req_valid <= 1'b0;
         end
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Acceptance is sampled at the rising edge; the accepted word leaves the
   // queue here and the predictor runs so that ordering follows the handshake.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         predict_cell_table(pending_words.pop_front());
      end
   end

   // Monitor: checks every response word against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("unexpected response word", 40'(rsp_cell_value), 40'd0);
         end else begin
            want = expected_cells.pop_front();
            words_checked++;
            if (rsp_cell_value !== want.value)
               report_mismatch("cell_value", 40'(rsp_cell_value), 40'(want.value));
            if (rsp_cell_status !== want.status)
               report_mismatch("cell_status", 40'(rsp_cell_status), 40'(want.status));
            if (rsp_hit_total !== want.hits)
               report_mismatch("hit_total", 40'(rsp_hit_total), 40'(want.hits));
            if (rsp_hits_saturated !== want.sat)
               report_mismatch("hits_saturated", 40'(rsp_hits_saturated), 40'(want.sat));
         end
      end
   end

   // Receiver hold-off: counts its own cycles while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         recv_hold <= 1'b1;
      end else begin
         recv_hold <= 1'b0;
      end
   end

   task automatic wait_ready_clear();
      while (pending_words.size() > 0) @(posedge clock);
   endtask

   // Waits until every queued word is taken and every response has arrived,
   // then lets the slowest word (a read with a divide) finish inside the block.
   task automatic drain_all();
      wait_ready_clear();
      while (expected_cells.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_COLS) cols_in_use = data[8:0];
      else max_height = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_word_type bin_word(input logic [23:0] v, input logic fin,
                                             input logic [15:0] h, input logic inb,
                                             input logic [7:0] r, input logic [7:0] c,
                                             input logic [15:0] b);
      req_word_type w;
      w = '0;
      w.action = ACT_BIN;
      w.value = v; w.finite = fin; w.height = h; w.inb = inb;
      w.row = r; w.col = c; w.bin = b;
      w.cell_no = 16'($urandom());
      return w;
   endfunction

   function automatic req_word_type cell_word(input logic [1:0] act, input logic [15:0] b,
                                              input logic [15:0] c);
      req_word_type w;
      w = REQ_W'({$urandom(), $urandom(), $urandom()});
      w.action = act;
      w.bin = b;
      w.cell_no = c;
      return w;
   endfunction

   // A small neighborhood of cells and bins keeps hits, fills and reads meeting.
   // Rows and, but for rare wide ones, columns stay small so that addresses under any column count
   // land on cells the reads also visit.
   task automatic random_phase(input int count);
      req_word_type w;
      logic [15:0]  b;
      int           n;
      int           kind;
      for (n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            w = bin_word(24'($urandom()), $urandom_range(9) != 0,
                         ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(900)),
                         $urandom_range(7) != 0, 8'($urandom_range(5)),
                         ($urandom_range(15) == 0) ? 8'($urandom()) : 8'($urandom_range(5)),
                         ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(31)));
         end else if (kind < 70) begin
            // Fill only from a bin that has been written since reset.
            b = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(31));
            if (!bin_written[b]) b = 16'd0;
            w = cell_word(ACT_FILL, b, ($urandom_range(7) == 0) ? 16'($urandom())
                                       : 16'($urandom_range(5) * cols_in_use
                                             + $urandom_range(5)));
         end else if (kind < 97) begin
            w = cell_word(ACT_READ, 16'($urandom()),
                          ($urandom_range(7) == 0) ? 16'($urandom())
                          : 16'($urandom_range(5) * cols_in_use + $urandom_range(5)));
         end else begin
            w = cell_word(ACT_UNUSED, 16'($urandom()), 16'($urandom()));
         end
         // Bin numbers written here become legal fill sources from now on.
         if (w.action == ACT_BIN) bin_written[w.bin] = 1'b1;
         pending_words.push_back(w);
      end
   endtask

   initial begin
      int n;
      cols_in_use = 9'd256;
      max_height = 16'hFFFF;
      for (n = 0; n < CELLS; n++) begin
         cell_sum[n] = '0; cell_hits[n] = '0; cell_sat[n] = 1'b0;
         cell_fill[n] = '0; cell_filled[n] = 1'b0;
      end
      for (n = 0; n < BINS; n++) begin
         bin_value[n] = '0; bin_usable[n] = 1'b0; bin_written[n] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings: extreme values, every action, the
      // last cell of the grid, a fill over hits and the unused action.
      pending_words.push_back(bin_word(24'h7FFFFF, 1'b1, 16'hFFFF, 1'b1, 8'hFF, 8'hFF,
                                       16'hFFFF));
      pending_words.push_back(bin_word(24'h800000, 1'b1, 16'd0, 1'b1, 8'd0, 8'd0, 16'd0));
      pending_words.push_back(bin_word(24'h7FFFFF, 1'b1, 16'd5, 1'b1, 8'd0, 8'd0, 16'd1));
      pending_words.push_back(bin_word(24'h000101, 1'b0, 16'd5, 1'b1, 8'd0, 8'd1, 16'd2));
      pending_words.push_back(bin_word(24'hFFFFFF, 1'b1, 16'd7, 1'b0, 8'd0, 8'd2, 16'd3));
      pending_words.push_back(cell_word(ACT_FILL, 16'd3, 16'd2));
      pending_words.push_back(cell_word(ACT_FILL, 16'd2, 16'd1));
      pending_words.push_back(cell_word(ACT_FILL, 16'd1, 16'd0));
      pending_words.push_back(cell_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'hFFFF));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd0));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd1));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd2));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd3));
      for (n = 0; n < 4; n++) bin_written[n] = 1'b1;
      bin_written[16'hFFFF] = 1'b1;
      drain_all();

      // Narrow grid and a low height limit; with one column, row 255 col 255
      // lands on cell 510.
      write_register(REG_COLS, 16'd1);
      write_register(REG_HEIGHT, 16'd0);
      pending_words.push_back(bin_word(24'h000010, 1'b1, 16'd0, 1'b1, 8'd255, 8'd255, 16'd4));
      pending_words.push_back(bin_word(24'h000020, 1'b1, 16'd1, 1'b1, 8'd3, 8'd0, 16'd5));
      pending_words.push_back(bin_word(24'hFFFFF0, 1'b1, 16'd0, 1'b1, 8'd3, 8'd0, 16'd6));
      pending_words.push_back(bin_word(24'hFFFFFD, 1'b1, 16'd0, 1'b1, 8'd3, 8'd0, 16'd7));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd3));
      pending_words.push_back(cell_word(ACT_READ, 16'd0, 16'd510));
      for (n = 4; n < 8; n++) bin_written[n] = 1'b1;
      drain_all();

      // Random phase one: the sender rarely idles, the receiver often does,
      // with a long receiver hold-off so the block backs up.
      write_register(REG_COLS, 16'd6);
      write_register(REG_HEIGHT, 16'd600);
      random_phase(200);
      hold_cycles = 400;
      random_phase(100);
      drain_all();

      // Random phase two at the widest grid: roles swapped.
      send_idle_pct = 58;
      recv_idle_pct = 9;
      write_register(REG_COLS, 16'd256);
      write_register(REG_HEIGHT, 16'hFFFF);
      random_phase(250);
      drain_all();

      // Random phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_COLS, 16'd3);
      write_register(REG_HEIGHT, 16'd300);
      random_phase(250);
      drain_all();

      if (error_count == 0 && expected_cells.size() == 0) begin
         $display("polar_bin_scatter_mean: match");
      end else begin
         $display("polar_bin_scatter_mean: mismatch");
      end
      $finish;
   end
endmodule
